[sv/assert_macros.svh]
// Shared assertion macros for the blit block checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define BBC_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bitmap_blit_clip assertion failed");

// Expression must never be true out of reset.
`define BBC_ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("bitmap_blit_clip forbidden condition seen");

`endif

[sv/bbc_pkg.sv]
package bbc_pkg;

    localparam int MAX_DIM_DEF     = 4096;
    localparam int ADDR_W          = 26;
    localparam int COLOR_W         = 24;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 14;
    localparam int GEOM_W          = 13;
    localparam int PITCH_W         = 14;
    localparam int BYTES_PER_PIXEL = 3;

    localparam logic [COLOR_W-1:0] WHITE = 24'hffffff;

    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FB_PITCH   = 3'd7;

    localparam logic MODE_1BPP  = 1'b0;
    localparam logic MODE_32BPP = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [COLOR_W-1:0] color;
        logic               visible;
        logic               last;
        logic               done;
    } pixel_t;

endpackage

[sv/bbc_ifs.sv]
interface bbc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_data;

    modport source (output valid, output pixel_data, input ready);
    modport sink (input valid, input pixel_data, output ready);
endinterface

interface bbc_out_if;
    logic        valid;
    logic        ready;
    logic [25:0] pixel_address;
    logic [23:0] pixel_color;
    logic        visible;
    logic        last;
    logic        image_done;

    modport source (output valid, output pixel_address, output pixel_color,
                    output visible, output last, output image_done, input ready);
    modport sink (input valid, input pixel_address, input pixel_color,
                  input visible, input last, input image_done, output ready);
endinterface

[sv/bbc_pixel.sv]
module bbc_pixel
    import bbc_pkg::*;
#(
    parameter int CNT_W = 12,
    parameter int DIM_W = CNT_W + 1
)
(
    input  logic                      mode,
    input  logic [31:0]               word,
    input  logic [2:0]                bit_idx,
    input  logic [CNT_W-1:0]          col,
    input  logic [CNT_W-1:0]          row,
    input  logic [DIM_W-1:0]          cols_c,
    input  logic [DIM_W-1:0]          rows_c,
    input  logic signed [GEOM_W-1:0]  x_off,
    input  logic signed [GEOM_W-1:0]  y_off,
    input  logic [GEOM_W-1:0]         fb_width,
    input  logic [GEOM_W-1:0]         fb_height,
    input  logic [PITCH_W-1:0]        fb_pitch,
    output pixel_t                    pix,
    output logic [CNT_W-1:0]          col_next,
    output logic [CNT_W-1:0]          row_next
);

    localparam int SUM_W  = ((CNT_W > GEOM_W) ? CNT_W : GEOM_W) + 2;
    localparam int PROD_W = SUM_W - 1 + PITCH_W;

    logic signed [SUM_W-1:0] fx;
    logic signed [SUM_W-1:0] fy;
    logic [SUM_W-2:0]        fx_u;
    logic [SUM_W-2:0]        fy_u;
    logic [PROD_W-1:0]       prod;
    logic [2:0]              sel;
    logic [DIM_W-1:0]        col_inc;
    logic [DIM_W-1:0]        cols_m1;
    logic [DIM_W-1:0]        rows_m1;
    logic                    vis;
    logic                    done;

    assign fx   = SUM_W'($signed({1'b0, col})) + SUM_W'(x_off);
    assign fy   = SUM_W'($signed({1'b0, row})) + SUM_W'(y_off);
    assign fx_u = fx[SUM_W-2:0];
    assign fy_u = fy[SUM_W-2:0];
    assign prod = PROD_W'(fy_u) * PROD_W'(fb_pitch)
                + PROD_W'(fx_u) * PROD_W'(BYTES_PER_PIXEL);
    assign vis  = !fx[SUM_W-1] && !fy[SUM_W-1]
               && (fx_u < (SUM_W-1)'(fb_width)) && (fy_u < (SUM_W-1)'(fb_height));

    assign sel     = 3'(3'd7 - bit_idx);
    assign col_inc = {1'b0, col} + DIM_W'(1);
    assign cols_m1 = cols_c - DIM_W'(1);
    assign rows_m1 = rows_c - DIM_W'(1);
    assign done    = (row == '0) && ({1'b0, col} >= cols_m1);

    always_comb
    begin
        pix.address = vis ? prod[ADDR_W-1:0] : '0;
        pix.visible = vis;
        pix.done    = done;
        pix.last    = done || (mode == MODE_32BPP) || (bit_idx == 3'd7);
        if (mode == MODE_32BPP)
        begin
            pix.color = word[COLOR_W-1:0];
        end
        else
        begin
            pix.color = word[sel] ? '0 : WHITE;
        end
    end

    always_comb
    begin
        col_next = col;
        row_next = row;
        if (done)
        begin
            col_next = '0;
            row_next = rows_m1[CNT_W-1:0];
        end
        else if (col_inc >= cols_c)
        begin
            col_next = '0;
            if ((row == '0) || ({1'b0, row} > rows_m1))
            begin
                row_next = rows_m1[CNT_W-1:0];
            end
            else
            begin
                row_next = row - CNT_W'(1);
            end
        end
        else
        begin
            col_next = col_inc[CNT_W-1:0];
        end
    end

endmodule

[sv/bitmap_blit_clip.sv]
// Channel    Dir  Handshake      Payload
// pixel_in   in   valid/ready    pixel_data[31:0]
// pixel_out  out  valid/ready    pixel_address[25:0], pixel_color[23:0], visible, last,
//                                image_done
// cfg        in   cfg_we         cfg_index[2:0], cfg_data[13:0]
//
// One pixel leaves per cycle while pixel_out does not stall: an item yields 8 pixels
// in 1bpp mode, 1 pixel in 32bpp mode, or fewer when the image ends inside a 1bpp byte.
// The pixel rate is set by the single address/clip unit between the item register
// and the output register; the next item is taken in the cycle its predecessor
// issues its last pixel.
// Reset clears configuration to its defaults and the walk to column 0, row 0.
// A stall on pixel_out holds the output register and the item register.
module bitmap_blit_clip
    import bbc_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    bbc_in_if.sink                pixel_in,
    bbc_out_if.source             pixel_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int DIM_W = CNT_W + 1;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [GEOM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (32'(v) > MAX_DIM)
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    logic                     mode_reg;
    logic [GEOM_W-1:0]        image_cols_reg;
    logic [GEOM_W-1:0]        image_rows_reg;
    logic signed [GEOM_W-1:0] x_offset_reg;
    logic signed [GEOM_W-1:0] y_offset_reg;
    logic [GEOM_W-1:0]        fb_width_reg;
    logic [GEOM_W-1:0]        fb_height_reg;
    logic [PITCH_W-1:0]       fb_pitch_reg;

    logic [CNT_W-1:0]         col_reg;
    logic [CNT_W-1:0]         row_reg;
    logic [CNT_W-1:0]         col_next;
    logic [CNT_W-1:0]         row_next;

    logic                     hold_valid_reg;
    logic [31:0]              hold_word_reg;
    logic [2:0]               hold_bit_reg;

    logic                     out_valid_reg;
    pixel_t                   out_pix_reg;
    pixel_t                   pix;

    logic [DIM_W-1:0]         cols_c;
    logic [DIM_W-1:0]         rows_c;
    logic [DIM_W-1:0]         restart_rows;
    logic                     step;
    logic                     in_take;

    assign cols_c  = clamp_dim(image_cols_reg);
    assign rows_c  = clamp_dim(image_rows_reg);
    assign step    = hold_valid_reg && (!out_valid_reg || pixel_out.ready);
    assign in_take = pixel_in.valid && pixel_in.ready;

    assign pixel_in.ready = !hold_valid_reg || (step && pix.last);

    assign restart_rows = clamp_dim(cfg_data[GEOM_W-1:0]) - DIM_W'(1);

    bbc_pixel #(
        .CNT_W (CNT_W),
        .DIM_W (DIM_W)
    ) u_pixel (
        .mode      (mode_reg),
        .word      (hold_word_reg),
        .bit_idx   (hold_bit_reg),
        .col       (col_reg),
        .row       (row_reg),
        .cols_c    (cols_c),
        .rows_c    (rows_c),
        .x_off     (x_offset_reg),
        .y_off     (y_offset_reg),
        .fb_width  (fb_width_reg),
        .fb_height (fb_height_reg),
        .fb_pitch  (fb_pitch_reg),
        .pix       (pix),
        .col_next  (col_next),
        .row_next  (row_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_1BPP;
            image_cols_reg <= GEOM_W'(1);
            image_rows_reg <= GEOM_W'(1);
            x_offset_reg   <= '0;
            y_offset_reg   <= '0;
            fb_width_reg   <= GEOM_W'(4096);
            fb_height_reg  <= GEOM_W'(4096);
            fb_pitch_reg   <= PITCH_W'(12288);
            col_reg        <= '0;
            row_reg        <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:       mode_reg <= cfg_data[0];
                REG_IMAGE_COLS:
                begin
                    image_cols_reg <= cfg_data[GEOM_W-1:0];
                    col_reg        <= '0;
                    row_reg        <= CNT_W'(rows_c - DIM_W'(1));
                end
                REG_IMAGE_ROWS:
                begin
                    image_rows_reg <= cfg_data[GEOM_W-1:0];
                    col_reg        <= '0;
                    row_reg        <= restart_rows[CNT_W-1:0];
                end
                REG_X_OFFSET:   x_offset_reg  <= cfg_data[GEOM_W-1:0];
                REG_Y_OFFSET:   y_offset_reg  <= cfg_data[GEOM_W-1:0];
                REG_FB_WIDTH:   fb_width_reg  <= cfg_data[GEOM_W-1:0];
                REG_FB_HEIGHT:  fb_height_reg <= cfg_data[GEOM_W-1:0];
                REG_FB_PITCH:   fb_pitch_reg  <= cfg_data;
            endcase
        end
        else if (step)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (step && pix.last)
            begin
                hold_valid_reg <= 1'b0;
            end

            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pixel_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            hold_word_reg <= pixel_in.pixel_data;
            hold_bit_reg  <= '0;
        end
        else if (step)
        begin
            hold_bit_reg <= hold_bit_reg + 3'd1;
        end

        if (step)
        begin
            out_pix_reg <= pix;
        end
    end

    assign pixel_out.valid         = out_valid_reg;
    assign pixel_out.pixel_address = out_pix_reg.address;
    assign pixel_out.pixel_color   = out_pix_reg.color;
    assign pixel_out.visible       = out_pix_reg.visible;
    assign pixel_out.last          = out_pix_reg.last;
    assign pixel_out.image_done    = out_pix_reg.done;

endmodule

[sv/bbc_checker.sv]
`include "assert_macros.svh"

module bbc_checker
    import bbc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [ADDR_W-1:0] out_address,
    input logic              out_visible,
    input logic              out_last,
    input logic              out_done
);

    `BBC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_address))
    `BBC_ASSERT(a_done_is_last, clk, rst_n, out_valid && out_done |-> out_last)
    `BBC_ASSERT(a_clip_addr_zero, clk, rst_n, out_valid && !out_visible |-> out_address == '0)
    `BBC_ASSERT_NEVER(a_no_take_mid_item, clk, rst_n, out_valid && !out_ready && !out_last && in_ready)

endmodule

bind bitmap_blit_clip bbc_checker u_bbc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (pixel_in.ready),
    .out_valid   (pixel_out.valid),
    .out_ready   (pixel_out.ready),
    .out_address (pixel_out.pixel_address),
    .out_visible (pixel_out.visible),
    .out_last    (pixel_out.last),
    .out_done    (pixel_out.image_done)
);
